FILE: sv/pwg_pkg.sv
// ----------------------------------------------------------------------------
// PID windup guard package
// Shared types and constants for the serial multiplier, the serial divider
// and the PID sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pwg_pkg;

    // Serial multiplier: 16-bit signed multiplier, one bit per cycle.
    localparam int MUL_STEPS = 16;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int MCAND_W   = 32;
    // The multiplicand shifts left through all multiplier bits.
    localparam int SHIFT_W   = MCAND_W + MUL_STEPS;
    // Three 48-bit products summed fit comfortably in 50 bits.
    localparam int ACC_W     = SHIFT_W + 2;

    // Serial divider: 16-bit error magnitude scaled by 2^24.
    localparam int DIVISOR_W = 16;
    localparam int QUO_W     = 40;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    // Configuration register indexes.
    localparam logic [2:0] CFG_KP     = 3'd0;
    localparam logic [2:0] CFG_KI     = 3'd1;
    localparam logic [2:0] CFG_KD     = 3'd2;
    localparam logic [2:0] CFG_WINDUP = 3'd3;

    typedef struct packed {
        logic start;
        logic clear_acc;
    } mul_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INC,
        ST_PROP,
        ST_INTG,
        ST_WAIT_DIV,
        ST_DERV,
        ST_DONE
    } pid_state_t;

endpackage

`default_nettype wire

FILE: sv/pid_controller_windup_guard_top.sv
// ----------------------------------------------------------------------------
// PID controller with integral windup guard
// Each input beat carries an error sample, a time step and a clear flag and
// produces one output beat with the saturated PID drive value.
//
// Channels: the input beat (error_sample, time_step, clear_integral) is taken
// on in_valid && in_ready; the result beat (drive_value, step_zero_flag) is
// handed over on out_valid && out_ready. Gains and the windup limit are set
// through cfg_write / cfg_index / cfg_data while the block is idle; the user
// must keep to that, as the block itself does not enforce it. Four products
// pass in turn through one bit-serial multiplier, with the serial divider
// running alongside, and then the result register is loaded.
// One item is in flight at a time; no new beat is taken until the result is loaded.
// The result sits in an output register; the next input beat is accepted
// while it waits. If the receiver stalls so long that a second result is
// ready, the block holds it until the first beat is taken.
// Reset clears the gains, the windup limit, the integral and the previous
// error, and leaves both channels empty.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_windup_guard_top
    import pwg_pkg::*;
(
    input  wire  logic               clk,
    input  wire  logic               rst_n,
    input  wire  logic               in_valid,
    output logic                     in_ready,
    input  wire  logic signed [15:0] error_sample,
    input  wire  logic [15:0]        time_step,
    input  wire  logic               clear_integral,
    output logic                     out_valid,
    input  wire  logic               out_ready,
    output logic signed [31:0]       drive_value,
    output logic                     step_zero_flag,
    input  wire  logic               cfg_write,
    input  wire  logic [2:0]         cfg_index,
    input  wire  logic [30:0]        cfg_data
);

    pid_state_t state_reg;
    pid_state_t state_next;

    logic signed [15:0] kp_reg;
    logic signed [15:0] ki_reg;
    logic signed [15:0] kd_reg;
    logic [30:0]        windup_reg;
    logic signed [31:0] integral_reg;
    logic signed [15:0] prev_error_reg;

    logic signed [15:0] error_reg;
    logic               clear_reg;
    logic               zero_step_reg;
    logic               deriv_neg_reg;
    logic               deriv_ready_reg;
    logic signed [31:0] deriv_reg;

    logic               out_valid_reg;
    logic signed [31:0] drive_reg;
    logic               flag_reg;

    logic               accept;
    logic               load_out;
    logic               update_integral;

    mul_ctrl_t                 mul_ctrl;
    logic signed [15:0]        mul_a;
    logic signed [MCAND_W-1:0] mul_b;
    logic signed [ACC_W-1:0]   mul_acc;
    logic                      mul_done;

    logic [QUO_W-1:0]   div_quo;
    logic               div_done;
    logic signed [16:0] delta;
    logic [15:0]        delta_mag;

    logic signed [24:0] increment;
    logic signed [31:0] integral_base;
    logic signed [33:0] integral_sum;
    logic signed [33:0] limit_pos;
    logic signed [33:0] limit_neg;
    logic signed [31:0] integral_next;

    logic signed [31:0] deriv_next;
    logic signed [41:0] drive_scaled;
    logic signed [31:0] drive_next;

    assign accept = in_valid && in_ready;

    // Derivative numerator magnitude, formed from the incoming sample.
    always_comb
    begin
        delta     = 17'(error_sample) - 17'(prev_error_reg);
        delta_mag = delta[16] ? 16'(-delta) : delta[15:0];
    end

    pwg_serial_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (mul_ctrl),
        .multiplier   (mul_a),
        .multiplicand (mul_b),
        .acc          (mul_acc),
        .done         (mul_done)
    );

    pwg_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && (time_step != '0)),
        .dividend ({delta_mag, 24'd0}),
        .divisor  (time_step),
        .quotient (div_quo),
        .done     (div_done)
    );

    // Integral update from the floored error*dt product.
    always_comb
    begin
        increment     = mul_acc[32:8];
        integral_base = clear_reg ? '0 : integral_reg;
        integral_sum  = 34'(integral_base) + 34'(increment);
        limit_pos     = $signed({3'b000, windup_reg});
        limit_neg     = -limit_pos;
        if (integral_sum > limit_pos)
        begin
            integral_next = limit_pos[31:0];
        end
        else if (integral_sum < limit_neg)
        begin
            integral_next = limit_neg[31:0];
        end
        else
        begin
            integral_next = integral_sum[31:0];
        end
    end

    // Signed, saturated derivative from the unsigned quotient.
    always_comb
    begin
        if (!deriv_neg_reg)
        begin
            deriv_next = (|div_quo[QUO_W-1:31]) ? 32'sh7FFF_FFFF
                                                : $signed({1'b0, div_quo[30:0]});
        end
        else if ((|div_quo[QUO_W-1:32]) || (div_quo[31] && (|div_quo[30:0])))
        begin
            deriv_next = 32'sh8000_0000;
        end
        else
        begin
            deriv_next = -$signed(div_quo[31:0]);
        end
    end

    // Final floor by 2^8 and saturation to 32 bits.
    always_comb
    begin
        drive_scaled = mul_acc[ACC_W-1:8];
        if (!drive_scaled[41] && (|drive_scaled[40:31]))
        begin
            drive_next = 32'sh7FFF_FFFF;
        end
        else if (drive_scaled[41] && !(&drive_scaled[40:31]))
        begin
            drive_next = 32'sh8000_0000;
        end
        else
        begin
            drive_next = drive_scaled[31:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        mul_ctrl        = '{start: 1'b0, clear_acc: 1'b0};
        mul_a           = '0;
        mul_b           = '0;
        load_out        = 1'b0;
        update_integral = 1'b0;
        in_ready        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mul_ctrl   = '{start: 1'b1, clear_acc: 1'b1};
                    mul_a      = error_sample;
                    mul_b      = $signed({16'd0, time_step});
                    state_next = ST_INC;
                end
            end
            ST_INC:
            begin
                if (mul_done)
                begin
                    update_integral = 1'b1;
                    mul_ctrl        = '{start: 1'b1, clear_acc: 1'b1};
                    mul_a           = kp_reg;
                    mul_b           = {{8{error_reg[15]}}, error_reg, 8'd0};
                    state_next      = ST_PROP;
                end
            end
            ST_PROP:
            begin
                if (mul_done)
                begin
                    mul_ctrl   = '{start: 1'b1, clear_acc: 1'b0};
                    mul_a      = ki_reg;
                    mul_b      = integral_reg;
                    state_next = ST_INTG;
                end
            end
            ST_INTG, ST_WAIT_DIV:
            begin
                if ((state_reg == ST_WAIT_DIV) || mul_done)
                begin
                    if (deriv_ready_reg)
                    begin
                        mul_ctrl   = '{start: 1'b1, clear_acc: 1'b0};
                        mul_a      = kd_reg;
                        mul_b      = deriv_reg;
                        state_next = ST_DERV;
                    end
                    else
                    begin
                        state_next = ST_WAIT_DIV;
                    end
                end
            end
            ST_DERV:
            begin
                if (mul_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= '0;
            ki_reg     <= '0;
            kd_reg     <= '0;
            windup_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_KP:     kp_reg     <= cfg_data[15:0];
                CFG_KI:     ki_reg     <= cfg_data[15:0];
                CFG_KD:     kd_reg     <= cfg_data[15:0];
                CFG_WINDUP: windup_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg    <= '0;
            prev_error_reg  <= '0;
            deriv_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prev_error_reg  <= error_sample;
                // A zero time step needs no division; the derivative is zero.
                deriv_ready_reg <= (time_step == '0);
            end
            else if (div_done)
            begin
                deriv_ready_reg <= 1'b1;
            end
            if (update_integral)
            begin
                integral_reg <= integral_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            error_reg     <= error_sample;
            clear_reg     <= clear_integral;
            zero_step_reg <= (time_step == '0);
            deriv_neg_reg <= delta[16];
            deriv_reg     <= '0;
        end
        else if (div_done)
        begin
            deriv_reg <= deriv_next;
        end
        if (load_out)
        begin
            drive_reg <= drive_next;
            flag_reg  <= zero_step_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign drive_value    = drive_reg;
    assign step_zero_flag = flag_reg;

endmodule

`default_nettype wire

FILE: sv/pwg_serial_mul.sv
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// Multiplies a signed 16-bit value by a signed 32-bit value one multiplier
// bit per cycle and adds the product into a signed accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module pwg_serial_mul
    import pwg_pkg::*;
(
    input  wire  logic                      clk,
    input  wire  logic                      rst_n,
    input  wire  mul_ctrl_t                 ctrl,
    input  wire  logic signed [15:0]        multiplier,
    input  wire  logic signed [MCAND_W-1:0] multiplicand,
    output logic signed [ACC_W-1:0]         acc,
    output logic                            done
);

    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_STEPS - 1);

    logic                      busy_reg;
    logic                      done_reg;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic [15:0]               mplier_reg;
    logic signed [SHIFT_W-1:0] mcand_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   term;
    logic signed [ACC_W-1:0]   acc_next;

    always_comb
    begin
        term = mplier_reg[0] ?
               {{(ACC_W - SHIFT_W){mcand_reg[SHIFT_W-1]}}, mcand_reg} : '0;
        // The top multiplier bit carries negative weight.
        if (cnt_reg == MUL_LAST)
        begin
            acc_next = acc_reg - term;
        end
        else
        begin
            acc_next = acc_reg + term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            mplier_reg <= multiplier;
            mcand_reg  <= {{MUL_STEPS{multiplicand[MCAND_W-1]}}, multiplicand};
            if (ctrl.clear_acc)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            mplier_reg <= {1'b0, mplier_reg[15:1]};
            mcand_reg  <= mcand_reg <<< 1;
            acc_reg    <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

FILE: sv/pwg_serial_div.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// Divides an unsigned dividend by a nonzero 16-bit divisor, producing one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwg_serial_div
    import pwg_pkg::*;
(
    input  wire  logic                 clk,
    input  wire  logic                 rst_n,
    input  wire  logic                 start,
    input  wire  logic [QUO_W-1:0]     dividend,
    input  wire  logic [DIVISOR_W-1:0] divisor,
    output logic [QUO_W-1:0]           quotient,
    output logic                       done
);

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[QUO_W-1]};
        diff    = shifted - {1'b0, divisor_reg};
        fits    = (shifted >= {1'b0, divisor_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out of the top of the quotient register while the
    // quotient bits shift in at the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            rem_reg     <= '0;
            quo_reg     <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

FILE: sv/pwg_checker.sv
// ----------------------------------------------------------------------------
// PID windup guard port checker
// Watches the top level's ports for sequencing and output stability rules.
// ----------------------------------------------------------------------------
`default_nettype none

module pwg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] drive_value,
    input wire logic        step_zero_flag
);

    // One item in flight: an accepted beat closes the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // An idle block stays ready until a beat arrives.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && !in_valid) |=> in_ready)
        else $error("block left idle without an input beat");

    // The serial datapath cannot produce a result right after acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared one cycle after acceptance");

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(drive_value) && $stable(step_zero_flag)))
        else $error("stalled result beat changed");

endmodule

bind pid_controller_windup_guard_top pwg_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drive_value    (drive_value),
    .step_zero_flag (step_zero_flag)
);

`default_nettype wire

FILE: tb/pid_controller_windup_guard_top_tb.sv
// ----------------------------------------------------------------------------
// PID controller with integral windup guard: self-checking testbench
// A table of directed beats and register writes runs first, then phases of
// random beats under extreme, then random, gain and clamp settings. Every input
// beat is run through a fixed-point model of the controller, and every output beat
// is compared with the oldest pending prediction. Both channels idle at random,
// and once the receiver stalls long enough to back the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_windup_guard_top_tb
    import pwg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_HIGH       = 10;
    localparam int HALF_LOW        = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int NUM_PHASES      = 9;
    localparam int BEATS_PER_PHASE = 100;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT  = 4000;

    // Indexes that decode to no register.
    localparam logic [2:0] CFG_SPARE_FIRST = CFG_WINDUP + 3'd1;
    localparam logic [2:0] CFG_SPARE_LAST  = '1;

    localparam logic signed [31:0] DRIVE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] DRIVE_MIN = 32'sh8000_0000;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [2:0]         idx;
        logic [30:0]        data;
        logic signed [15:0] err;
        logic [15:0]        dt;
        logic               clr;
        bit                 known;
        logic signed [31:0] drive;
        logic               zflag;
    } stim_row_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               zflag;
    } pid_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] error_sample;
    logic [15:0]        time_step;
    logic               clear_integral;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] drive_value;
    logic               step_zero_flag;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [30:0]        cfg_data;

    // Model copy of the configuration and the controller state.
    logic signed [15:0] kp_q;
    logic signed [15:0] ki_q;
    logic signed [15:0] kd_q;
    logic [30:0]        windup_q;
    logic signed [31:0] integ_q;
    logic signed [15:0] prev_err_q;

    pid_result_t pending_results[$];
    stim_row_t   plan[$];
    int          err_count;
    int          beat_count;
    int          send_burst;
    int          idle_cycles;
    bit          hold_req;

    pid_controller_windup_guard_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .error_sample   (error_sample),
        .time_step      (time_step),
        .clear_integral (clear_integral),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_value    (drive_value),
        .step_zero_flag (step_zero_flag),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #HALF_HIGH;
        clk = 1'b0;
        #HALF_LOW;
    end

    function automatic longint sat32(input longint x);
        if (x > longint'(DRIVE_MAX))
            return longint'(DRIVE_MAX);
        if (x < longint'(DRIVE_MIN))
            return longint'(DRIVE_MIN);
        return x;
    endfunction

    // One controller step; updates the model state like the block does.
    function automatic void pid_predict(input logic signed [15:0] err,
                                        input logic [15:0] dt, input logic clr,
                                        output pid_result_t res);
        longint ev;
        longint dtv;
        longint lim;
        longint acc;
        longint deriv;
        longint sum;
        ev  = err;
        dtv = dt;
        lim = windup_q;
        if (clr)
            acc = 0;
        else
            acc = integ_q;
        // Arithmetic shift floors the Q.24 increment down to Q15.16.
        acc = acc + ((ev * dtv) >>> 8);
        if (acc > lim)
            acc = lim;
        if (acc < -lim)
            acc = -lim;
        integ_q = acc[31:0];
        deriv = 0;
        if (dtv != 0)
            deriv = sat32(((ev - longint'(prev_err_q)) * 64'sd16777216) / dtv);
        sum = longint'(kp_q) * ev * 256 + longint'(ki_q) * acc
            + longint'(kd_q) * deriv;
        sum = sat32(sum >>> 8);
        prev_err_q = err;
        res.drive = sum[31:0];
        res.zflag = (dtv == 0);
    endfunction

    function automatic stim_row_t item_row(input logic signed [15:0] err,
                                           input logic [15:0] dt, input logic clr);
        stim_row_t r;
        r = '{ROW_ITEM, CFG_KP, '0, err, dt, clr, 1'b0, '0, 1'b0};
        return r;
    endfunction

    function automatic stim_row_t known_row(input logic signed [15:0] err,
                                            input logic [15:0] dt, input logic clr,
                                            input logic signed [31:0] drive,
                                            input logic zflag);
        stim_row_t r;
        r = '{ROW_ITEM, CFG_KP, '0, err, dt, clr, 1'b1, drive, zflag};
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [30:0] data);
        stim_row_t r;
        r = '{ROW_CFG, idx, data, '0, '0, 1'b0, 1'b0, '0, 1'b0};
        return r;
    endfunction

    // Mostly short gaps, a few long ones; never zero.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    function automatic logic signed [15:0] pick_error();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 16'sh7FFF;
        if (r < 10)
            return 16'sh8000;
        if (r < 13)
            return 16'sh0000;
        if (r < 15)
            return -16'sd1;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'h0000;
        if (r < 25)
            return 16'($urandom_range(1, 8));
        if (r < 30)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic logic [30:0] pick_gain_word();
        int r;
        logic [15:0] g;
        r = $urandom_range(0, 99);
        if (r < 8)
            g = 16'h7FFF;
        else if (r < 16)
            g = 16'h8000;
        else if (r < 20)
            g = 16'h0000;
        else if (r < 45)
            g = 16'($signed($urandom_range(0, 1024)) - 512);
        else
            g = 16'($urandom);
        // Bits above the gain width are junk the block must drop.
        return {15'($urandom), g};
    endfunction

    function automatic logic [30:0] pick_windup();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 31'h7FFF_FFFF;
        if (r < 35)
            return 31'h0;
        if (r < 65)
            return 31'($urandom_range(0, 1 << 20));
        return 31'($urandom);
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("mismatch at %0t ns: %s", $realtime, msg);
    endtask

    // Drop valid and wait until every predicted beat has come back.
    task automatic wait_block_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_KP:     kp_q = data[15:0];
            CFG_KI:     ki_q = data[15:0];
            CFG_KD:     kd_q = data[15:0];
            CFG_WINDUP: windup_q = data;
            default:    ;
        endcase
    endtask

    task automatic send_item(input logic signed [15:0] err, input logic [15:0] dt,
                             input logic clr, input bit known,
                             input logic signed [31:0] known_drive,
                             input logic known_flag);
        int gap;
        int r;
        pid_result_t res;
        if (send_burst > 0)
        begin
            send_burst--;
            gap = 0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                gap = 0;
            else if (r < 50)
            begin
                send_burst = $urandom_range(30, 120);
                gap = 0;
            end
            else
                gap = pick_gap();
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        error_sample   <= err;
        time_step      <= dt;
        clear_integral <= clr;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        pid_predict(err, dt, clr, res);
        if (known)
        begin
            res.drive = known_drive;
            res.zflag = known_flag;
        end
        pending_results.push_back(res);
    endtask

    task automatic set_random_phase(input int phase);
        if (phase == 0)
        begin
            write_reg(CFG_KP, 31'h0000_7FFF);
            write_reg(CFG_KI, 31'h0000_7FFF);
            write_reg(CFG_KD, 31'h0000_7FFF);
            write_reg(CFG_WINDUP, 31'h7FFF_FFFF);
        end
        else if (phase == 1)
        begin
            write_reg(CFG_KP, 31'h0000_8000);
            write_reg(CFG_KI, 31'h0000_8000);
            write_reg(CFG_KD, 31'h0000_8000);
            write_reg(CFG_WINDUP, 31'h0);
        end
        else
        begin
            write_reg(CFG_KP, pick_gain_word());
            write_reg(CFG_KI, pick_gain_word());
            write_reg(CFG_KD, pick_gain_word());
            write_reg(CFG_WINDUP, pick_windup());
        end
        if ($urandom_range(0, 1) == 1)
            write_reg(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), 31'($urandom));
    endtask

    // Receiver: random stalls, ready stretches, and one forced long hold.
    initial
    begin : receiver
        int stall_left;
        int free_left;
        int pick;
        stall_left = 0;
        free_left  = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (free_left > 0)
            begin
                free_left--;
                out_ready <= 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    out_ready <= 1'b1;
                else if (pick < 65)
                begin
                    free_left = $urandom_range(50, 300);
                    out_ready <= 1'b1;
                end
                else
                begin
                    stall_left = pick_gap() - 1;
                    out_ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        pid_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beat_count++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result beat %0d with nothing pending",
                                          beat_count));
            else
            begin
                want = pending_results.pop_front();
                if (drive_value !== want.drive)
                    report_mismatch($sformatf("beat %0d drive_value %0d, predicted %0d",
                                              beat_count, drive_value, want.drive));
                if (step_zero_flag !== want.zflag)
                    report_mismatch($sformatf("beat %0d step_zero_flag %b, predicted %b",
                                              beat_count, step_zero_flag, want.zflag));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int phase;
        int n;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        error_sample   = '0;
        time_step      = '0;
        clear_integral = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_KP;
        cfg_data       = '0;
        kp_q           = '0;
        ki_q           = '0;
        kd_q           = '0;
        windup_q       = '0;
        integ_q        = '0;
        prev_err_q     = '0;
        err_count      = 0;
        beat_count     = 0;
        send_burst     = 0;
        idle_cycles    = 0;
        hold_req       = 1'b0;

        // Gains and clamp are zero out of reset, so the drive is zero.
        plan.push_back(known_row(16'sh7FFF, 16'hFFFF, 1'b0, 32'sd0, 1'b0));
        plan.push_back(known_row(16'sh8000, 16'h0000, 1'b0, 32'sd0, 1'b1));
        plan.push_back(known_row(16'sh0000, 16'h0000, 1'b1, 32'sd0, 1'b1));
        plan.push_back(cfg_row(CFG_KP, 31'h0000_7FFF));
        plan.push_back(cfg_row(CFG_KI, 31'h0000_7FFF));
        plan.push_back(cfg_row(CFG_KD, 31'h0000_7FFF));
        plan.push_back(cfg_row(CFG_WINDUP, 31'h7FFF_FFFF));
        plan.push_back(item_row(16'sh7FFF, 16'hFFFF, 1'b0));
        // Full-scale error swings over the shortest step saturate the derivative.
        plan.push_back(known_row(16'sh8000, 16'h0001, 1'b0, DRIVE_MIN, 1'b0));
        plan.push_back(known_row(16'sh7FFF, 16'h0001, 1'b0, DRIVE_MAX, 1'b0));
        plan.push_back(item_row(16'sh7FFF, 16'h0000, 1'b1));
        plan.push_back(item_row(16'sh0000, 16'hFFFF, 1'b1));
        plan.push_back(item_row(-16'sd1, 16'h0001, 1'b0));
        plan.push_back(item_row(16'sh0100, 16'h1000, 1'b0));
        plan.push_back(cfg_row(CFG_KP, 31'h7FFF_8000));
        plan.push_back(cfg_row(CFG_KI, 31'h0000_8000));
        plan.push_back(cfg_row(CFG_KD, 31'h0000_8000));
        plan.push_back(cfg_row(CFG_WINDUP, 31'h0001_0000));
        plan.push_back(item_row(16'sh7FFF, 16'hFFFF, 1'b0));
        plan.push_back(item_row(16'sh8000, 16'hFFFF, 1'b0));
        plan.push_back(item_row(16'sh8000, 16'h0001, 1'b0));
        plan.push_back(known_row(16'sh7FFF, 16'h0001, 1'b0, DRIVE_MIN, 1'b0));
        // Writes to undecoded indexes must leave every register alone.
        plan.push_back(cfg_row(CFG_SPARE_FIRST, 31'h7FFF_FFFF));
        plan.push_back(cfg_row(CFG_SPARE_LAST, 31'h7FFF_FFFF));
        plan.push_back(item_row(16'sh1234, 16'h0400, 1'b0));
        plan.push_back(cfg_row(CFG_WINDUP, 31'h0));
        plan.push_back(item_row(-16'sd1, 16'hFFFF, 1'b0));
        plan.push_back(item_row(16'sh0080, 16'h8000, 1'b1));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                wait_block_idle();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                send_item(plan[i].err, plan[i].dt, plan[i].clr, plan[i].known,
                          plan[i].drive, plan[i].zflag);
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_block_idle();
            set_random_phase(phase);
            for (n = 0; n < BEATS_PER_PHASE; n++)
            begin
                // Back the block up once while the sender keeps offering.
                if (phase == 2 && n == 10)
                    hold_req = 1'b1;
                send_item(pick_error(), pick_step(), ($urandom_range(0, 99) < 8),
                          1'b0, '0, 1'b0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d predicted beats never arrived",
                                      pending_results.size()));
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
